/* rtl/core/mjss_pkg.sv */
package mjss_pkg;

    localparam int NREG        = 6;
    localparam int JW          = 3;
    localparam int AW          = 8;
    localparam int DEF_JOINTS  = 6;
    localparam int DEF_BASE    = 20;
    localparam int DEF_ALLSPD  = 5;
    localparam int SPEED_MAX   = 10;
    localparam int DIV_STEPS   = 16;
    localparam logic [31:0] SETUP_RST = 32'h055A_B400;
    localparam logic [AW-1:0] HOME_RST = 8'd90;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_MOVE1 = 3'd1,
        CMD_MOVEA = 3'd2,
        CMD_HOME  = 3'd3,
        CMD_INIT  = 3'd4,
        CMD_QUERY = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        K_UPDATE = 3'd0,
        K_ACCEPT = 3'd1,
        K_REJECT = 3'd2,
        K_DONE   = 3'd3,
        K_REPORT = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_ONE     = 2'd1,
        MODE_HOMEALL = 2'd2,
        MODE_ALL     = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_ONE_STEP, S_ALL_INC, S_DIV_LOAD, S_DIV_RUN,
        S_ALL_EMIT, S_ALL_FIN, S_INIT, S_DONE_ITEM, S_DONE_ACT, S_DONE_ZERO
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LATCH, OP_TICK, OP_START_ONE, OP_START_ALL, OP_START_HOME,
        OP_ONE_STEP, OP_ALL_INC, OP_DIV_LOAD, OP_DIV_RUN, OP_ALL_EMIT,
        OP_ALL_FIN, OP_IDX_CLR, OP_INIT_J
    } op_t;

    typedef enum logic [3:0] {
        EM_NONE, EM_REJECT, EM_ACC_ITEM, EM_ACC_ZERO, EM_DONE_ITEM,
        EM_DONE_ACTIVE, EM_DONE_ZERO, EM_UPD_ONE, EM_UPD_ALL, EM_UPD_INIT,
        EM_REPORT
    } em_t;

    typedef struct packed {
        op_t  op;
        em_t  em;
        logic busy;
        logic last;
    } ctl_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       all_joints;
        mode_t      mode;
        logic       jvalid;
        logic       one_zero;
        logic       mx_zero;
        logic       home_found;
        logic       tick_fire;
        logic       step_done;
        logic       next_found;
        logic       idx_last;
        logic       all_fin;
        logic       div_last;
        logic       slot;
    } sts_t;

    function automatic logic [AW-1:0] f_min(input logic [31:0] r);
        return r[7:0];
    endfunction

    function automatic logic [AW-1:0] f_max(input logic [31:0] r);
        return r[15:8];
    endfunction

    function automatic logic [AW-1:0] f_home(input logic [31:0] r);
        return r[23:16];
    endfunction

    function automatic logic [3:0] f_speed(input logic [31:0] r);
        return r[27:24];
    endfunction

    function automatic logic [3:0] f_chan(input logic [31:0] r);
        return r[31:28];
    endfunction

    function automatic logic [AW-1:0] clamp(input logic [AW-1:0] a,
                                            input logic [31:0] r);
        logic [AW-1:0] res;
        res = a;
        if (a < f_min(r))
            res = f_min(r);
        else if (a > f_max(r))
            res = f_max(r);
        return res;
    endfunction

    // Period floor of one tick.
    function automatic logic [4:0] per_of(input int q);
        logic [4:0] p;
        p = 5'(q);
        if (q == 0)
            p = 5'd1;
        return p;
    endfunction

endpackage

/* rtl/core/mjss_ctrl.sv */
module mjss_ctrl
    import mjss_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic item_valid,
    output logic item_ready,
    input  sts_t sts,
    output ctl_t ctl
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '{op: OP_NONE, em: EM_NONE, busy: 1'b0, last: 1'b0};
        item_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    ctl.op     = OP_LATCH;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (sts.cmd == CMD_TICK)
                begin
                    if (sts.mode == MODE_IDLE)
                        state_next = S_IDLE;
                    else
                    begin
                        ctl.op = OP_TICK;
                        if (!sts.tick_fire)
                            state_next = S_IDLE;
                        else if (sts.mode == MODE_ALL)
                            state_next = S_ALL_INC;
                        else
                            state_next = S_ONE_STEP;
                    end
                end
                else if (sts.cmd > CMD_QUERY)
                    state_next = S_IDLE;
                else if (sts.cmd == CMD_INIT && sts.mode == MODE_IDLE)
                begin
                    ctl.op     = OP_IDX_CLR;
                    state_next = S_INIT;
                end
                else if (sts.slot)
                begin
                    if (sts.mode != MODE_IDLE)
                    begin
                        ctl.em     = EM_REJECT;
                        ctl.busy   = 1'b1;
                        ctl.last   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (sts.cmd == CMD_MOVE1 ||
                             (sts.cmd == CMD_HOME && !sts.all_joints))
                    begin
                        ctl.op = OP_START_ONE;
                        ctl.em = EM_ACC_ITEM;
                        if (!sts.jvalid || sts.one_zero)
                            state_next = S_DONE_ITEM;
                        else
                        begin
                            ctl.busy   = 1'b1;
                            ctl.last   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    else if (sts.cmd == CMD_MOVEA)
                    begin
                        ctl.op     = OP_START_ALL;
                        ctl.em     = EM_ACC_ZERO;
                        ctl.busy   = !sts.mx_zero;
                        ctl.last   = !sts.mx_zero;
                        state_next = sts.mx_zero ? S_DONE_ZERO : S_IDLE;
                    end
                    else if (sts.cmd == CMD_HOME)
                    begin
                        ctl.op     = OP_START_HOME;
                        ctl.em     = EM_ACC_ZERO;
                        ctl.busy   = sts.home_found;
                        ctl.last   = sts.home_found;
                        state_next = sts.home_found ? S_IDLE : S_DONE_ZERO;
                    end
                    else
                    begin
                        ctl.em     = EM_REPORT;
                        ctl.last   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_ONE_STEP:
            begin
                if (sts.slot)
                begin
                    ctl.op   = OP_ONE_STEP;
                    ctl.em   = EM_UPD_ONE;
                    ctl.busy = 1'b1;
                    ctl.last = !sts.step_done ||
                               (sts.mode == MODE_HOMEALL && sts.next_found);
                    if (ctl.last)
                        state_next = S_IDLE;
                    else if (sts.mode == MODE_HOMEALL)
                        state_next = S_DONE_ZERO;
                    else
                        state_next = S_DONE_ACT;
                end
            end
            S_ALL_INC:
            begin
                ctl.op     = OP_ALL_INC;
                state_next = S_DIV_LOAD;
            end
            S_DIV_LOAD:
            begin
                ctl.op     = OP_DIV_LOAD;
                state_next = S_DIV_RUN;
            end
            S_DIV_RUN:
            begin
                ctl.op = OP_DIV_RUN;
                if (sts.div_last)
                    state_next = S_ALL_EMIT;
            end
            S_ALL_EMIT:
            begin
                if (sts.slot)
                begin
                    ctl.op   = OP_ALL_EMIT;
                    ctl.em   = EM_UPD_ALL;
                    ctl.busy = 1'b1;
                    ctl.last = sts.idx_last && !sts.all_fin;
                    if (!sts.idx_last)
                        state_next = S_DIV_LOAD;
                    else if (sts.all_fin)
                        state_next = S_ALL_FIN;
                    else
                        state_next = S_IDLE;
                end
            end
            S_ALL_FIN:
            begin
                if (sts.slot)
                begin
                    ctl.op     = OP_ALL_FIN;
                    ctl.em     = EM_DONE_ZERO;
                    ctl.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_INIT:
            begin
                if (sts.slot)
                begin
                    ctl.op = OP_INIT_J;
                    ctl.em = EM_UPD_INIT;
                    if (sts.idx_last)
                        state_next = S_DONE_ZERO;
                end
            end
            S_DONE_ITEM:
            begin
                if (sts.slot)
                begin
                    ctl.em     = EM_DONE_ITEM;
                    ctl.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DONE_ACT:
            begin
                if (sts.slot)
                begin
                    ctl.em     = EM_DONE_ACTIVE;
                    ctl.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DONE_ZERO:
            begin
                if (sts.slot)
                begin
                    ctl.em     = EM_DONE_ZERO;
                    ctl.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

/* rtl/core/mjss_dp.sv */
module mjss_dp
    import mjss_pkg::*;
#(
    parameter int JOINTS      = DEF_JOINTS,
    parameter int BASE_PERIOD = DEF_BASE,
    parameter int ALL_SPEED   = DEF_ALLSPD
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_idx,
    input  logic [31:0]   cfg_data,
    input  logic [2:0]    cmd,
    input  logic [JW-1:0] joint,
    input  logic          all_joints,
    input  logic [AW-1:0] target,
    input  logic [AW-1:0] angle_in [NREG],
    input  ctl_t          ctl,
    output sts_t          sts,
    output logic          res_valid,
    input  logic          res_ready,
    output logic [2:0]    kind,
    output logic [3:0]    channel,
    output logic [JW-1:0] joint_out,
    output logic [AW-1:0] angle_out,
    output logic          busy_res,
    output logic          last
);

    localparam logic [4:0] ALL_PER = per_of(BASE_PERIOD / ALL_SPEED);

    logic [31:0]    setup_reg [NREG];
    logic [AW-1:0]  stored_reg [NREG];
    logic [AW-1:0]  goal_reg [NREG];
    logic [AW-1:0]  moving_reg;
    mode_t          mode_reg;
    logic [JW-1:0]  active_reg;
    logic [AW-1:0]  step_idx_reg;
    logic [AW-1:0]  step_tot_reg;
    logic [4:0]     tick_reg;
    logic [JW-1:0]  idx_reg;

    logic [2:0]     it_cmd_reg;
    logic [JW-1:0]  it_j_reg;
    logic           it_all_reg;
    logic [AW-1:0]  it_tgt_reg;
    logic [AW-1:0]  it_ang_reg [NREG];

    logic [15:0]    div_q_reg;
    logic [8:0]     div_r_reg;
    logic [4:0]     div_cnt_reg;
    logic           div_neg_reg;

    logic           rv_reg;
    logic [2:0]     kind_reg;
    logic [3:0]     chan_reg;
    logic [JW-1:0]  jo_reg;
    logic [AW-1:0]  ao_reg;
    logic           busy_reg;
    logic           last_reg;

    logic           jvalid;
    logic [JW-1:0]  jv;
    logic [AW-1:0]  tgt_one;
    logic [AW-1:0]  g_one;
    logic [AW-1:0]  g_all [NREG];
    logic [AW-1:0]  g_home [NREG];
    logic [AW-1:0]  delta;
    logic [AW-1:0]  mx;
    logic           home_found;
    logic [JW-1:0]  home_nx;
    logic           next_found;
    logic [JW-1:0]  next_nx;
    logic [3:0]     spd;
    logic [4:0]     per;
    logic [4:0]     tick_inc;
    logic [AW-1:0]  mv_next;
    logic [AW-1:0]  m_div;
    logic [AW-1:0]  mag;
    logic [8:0]     r_sh;
    logic           ge;
    logic [AW-1:0]  v_all;
    logic           slot;
    logic           emit;
    logic [2:0]     e_kind;
    logic [3:0]     e_chan;
    logic [JW-1:0]  e_j;
    logic [AW-1:0]  e_ang;

    // Item decode and candidate goals.
    always_comb
    begin
        jvalid  = 32'(it_j_reg) < JOINTS;
        jv      = jvalid ? it_j_reg : '0;
        tgt_one = (it_cmd_reg == CMD_MOVE1) ? it_tgt_reg : f_home(setup_reg[jv]);
        g_one   = clamp(tgt_one, setup_reg[jv]);
        mx      = '0;
        delta   = '0;
        home_found = 1'b0;
        home_nx = '0;
        next_found = 1'b0;
        next_nx = '0;
        for (int i = 0; i < NREG; i++)
        begin
            g_all[i]  = clamp(it_ang_reg[i], setup_reg[i]);
            g_home[i] = clamp(f_home(setup_reg[i]), setup_reg[i]);
        end
        for (int i = 0; i < JOINTS; i++)
        begin
            delta = (g_all[i] > stored_reg[i]) ? g_all[i] - stored_reg[i]
                                               : stored_reg[i] - g_all[i];
            if (delta > mx)
                mx = delta;
            if (!home_found && g_home[i] != stored_reg[i])
            begin
                home_found = 1'b1;
                home_nx    = JW'(i);
            end
            if (!next_found && JW'(i) > active_reg && goal_reg[i] != stored_reg[i])
            begin
                next_found = 1'b1;
                next_nx    = JW'(i);
            end
        end
    end

    // Step period.
    always_comb
    begin
        spd = f_speed(setup_reg[active_reg]);
        case (spd)
            4'd0, 4'd1: per = per_of(BASE_PERIOD / 1);
            4'd2:       per = per_of(BASE_PERIOD / 2);
            4'd3:       per = per_of(BASE_PERIOD / 3);
            4'd4:       per = per_of(BASE_PERIOD / 4);
            4'd5:       per = per_of(BASE_PERIOD / 5);
            4'd6:       per = per_of(BASE_PERIOD / 6);
            4'd7:       per = per_of(BASE_PERIOD / 7);
            4'd8:       per = per_of(BASE_PERIOD / 8);
            4'd9:       per = per_of(BASE_PERIOD / 9);
            default:    per = per_of(BASE_PERIOD / SPEED_MAX);
        endcase
        if (mode_reg == MODE_ALL)
            per = ALL_PER;
        tick_inc = tick_reg + 5'd1;
    end

    always_comb
    begin
        mv_next = moving_reg;
        if (goal_reg[active_reg] > moving_reg)
            mv_next = moving_reg + 8'd1;
        else if (goal_reg[active_reg] < moving_reg)
            mv_next = moving_reg - 8'd1;
        m_div = (step_tot_reg == '0) ? 8'd1 : step_tot_reg;
        mag   = (goal_reg[idx_reg] < stored_reg[idx_reg])
              ? stored_reg[idx_reg] - goal_reg[idx_reg]
              : goal_reg[idx_reg] - stored_reg[idx_reg];
        r_sh  = {div_r_reg[7:0], div_q_reg[15]};
        ge    = r_sh >= {1'b0, m_div};
        v_all = div_neg_reg ? stored_reg[idx_reg] - div_q_reg[7:0]
                            : stored_reg[idx_reg] + div_q_reg[7:0];
    end

    assign slot = !rv_reg || res_ready;
    assign emit = ctl.em != EM_NONE;

    always_comb
    begin
        sts.cmd        = it_cmd_reg;
        sts.all_joints = it_all_reg;
        sts.mode       = mode_reg;
        sts.jvalid     = jvalid;
        sts.one_zero   = g_one == stored_reg[jv];
        sts.mx_zero    = mx == '0;
        sts.home_found = home_found;
        sts.tick_fire  = tick_inc >= per;
        sts.step_done  = mv_next == goal_reg[active_reg];
        sts.next_found = next_found;
        sts.idx_last   = 32'(idx_reg) == JOINTS - 1;
        sts.all_fin    = step_idx_reg >= step_tot_reg;
        sts.div_last   = div_cnt_reg == 5'd1;
        sts.slot       = slot;
    end

    // Result field select.
    always_comb
    begin
        e_kind = K_DONE;
        e_chan = '0;
        e_j    = '0;
        e_ang  = '0;
        case (ctl.em)
            EM_REJECT:
            begin
                e_kind = K_REJECT;
                e_j    = it_j_reg;
            end
            EM_ACC_ITEM:
            begin
                e_kind = K_ACCEPT;
                e_j    = it_j_reg;
                e_ang  = jvalid ? g_one : '0;
            end
            EM_ACC_ZERO:
                e_kind = K_ACCEPT;
            EM_DONE_ITEM:
            begin
                e_j   = it_j_reg;
                e_ang = jvalid ? goal_reg[jv] : '0;
            end
            EM_DONE_ACTIVE:
            begin
                e_j   = active_reg;
                e_ang = goal_reg[active_reg];
            end
            EM_UPD_ONE:
            begin
                e_kind = K_UPDATE;
                e_chan = f_chan(setup_reg[active_reg]);
                e_j    = active_reg;
                e_ang  = mv_next;
            end
            EM_UPD_ALL:
            begin
                e_kind = K_UPDATE;
                e_chan = f_chan(setup_reg[idx_reg]);
                e_j    = idx_reg;
                e_ang  = v_all;
            end
            EM_UPD_INIT:
            begin
                e_kind = K_UPDATE;
                e_chan = f_chan(setup_reg[idx_reg]);
                e_j    = idx_reg;
                e_ang  = f_home(setup_reg[idx_reg]);
            end
            EM_REPORT:
            begin
                e_kind = K_REPORT;
                e_j    = it_j_reg;
                e_ang  = jvalid ? stored_reg[jv] : '0;
            end
            default:
                e_kind = K_DONE;
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rv_reg <= 1'b0;
        else if (emit)
            rv_reg <= 1'b1;
        else if (res_ready)
            rv_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg <= e_kind;
            chan_reg <= e_chan;
            jo_reg   <= e_j;
            ao_reg   <= e_ang;
            busy_reg <= ctl.busy;
            last_reg <= ctl.last;
        end
    end

    // Item capture and divider.
    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_LATCH)
        begin
            it_cmd_reg <= cmd;
            it_j_reg   <= joint;
            it_all_reg <= all_joints;
            it_tgt_reg <= target;
            it_ang_reg <= angle_in;
        end
        if (ctl.op == OP_DIV_LOAD)
        begin
            div_q_reg   <= step_idx_reg * mag;
            div_r_reg   <= '0;
            div_cnt_reg <= 5'(DIV_STEPS);
            div_neg_reg <= goal_reg[idx_reg] < stored_reg[idx_reg];
        end
        else if (ctl.op == OP_DIV_RUN)
        begin
            div_q_reg   <= {div_q_reg[14:0], ge};
            div_r_reg   <= ge ? r_sh - {1'b0, m_div} : r_sh;
            div_cnt_reg <= div_cnt_reg - 5'd1;
        end
    end

    // Motion state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NREG; i++)
            begin
                setup_reg[i]  <= SETUP_RST | (32'(i) << 28);
                stored_reg[i] <= HOME_RST;
                goal_reg[i]   <= '0;
            end
            moving_reg   <= '0;
            mode_reg     <= MODE_IDLE;
            active_reg   <= '0;
            step_idx_reg <= '0;
            step_tot_reg <= '0;
            tick_reg     <= '0;
            idx_reg      <= '0;
        end
        else
        begin
            if (cfg_we && 32'(cfg_idx) < NREG)
                setup_reg[cfg_idx] <= cfg_data;
            case (ctl.op)
                OP_TICK:
                    tick_reg <= (tick_inc >= per) ? 5'd0 : tick_inc;
                OP_START_ONE:
                begin
                    if (jvalid)
                    begin
                        goal_reg[jv] <= g_one;
                        if (g_one != stored_reg[jv])
                        begin
                            mode_reg   <= MODE_ONE;
                            active_reg <= jv;
                            moving_reg <= stored_reg[jv];
                            tick_reg   <= '0;
                        end
                    end
                end
                OP_START_ALL:
                begin
                    goal_reg <= g_all;
                    if (mx != '0)
                    begin
                        mode_reg     <= MODE_ALL;
                        step_idx_reg <= '0;
                        step_tot_reg <= mx;
                        tick_reg     <= '0;
                    end
                end
                OP_START_HOME:
                begin
                    goal_reg <= g_home;
                    if (home_found)
                    begin
                        mode_reg   <= MODE_HOMEALL;
                        active_reg <= home_nx;
                        moving_reg <= stored_reg[home_nx];
                        tick_reg   <= '0;
                    end
                end
                OP_ONE_STEP:
                begin
                    moving_reg <= mv_next;
                    if (mv_next == goal_reg[active_reg])
                    begin
                        stored_reg[active_reg] <= goal_reg[active_reg];
                        if (mode_reg == MODE_HOMEALL && next_found)
                        begin
                            active_reg <= next_nx;
                            moving_reg <= stored_reg[next_nx];
                            tick_reg   <= '0;
                        end
                        else
                            mode_reg <= MODE_IDLE;
                    end
                end
                OP_ALL_INC:
                begin
                    step_idx_reg <= step_idx_reg + 8'd1;
                    idx_reg      <= '0;
                end
                OP_ALL_EMIT:
                    idx_reg <= idx_reg + 3'd1;
                OP_ALL_FIN:
                begin
                    stored_reg <= goal_reg;
                    mode_reg   <= MODE_IDLE;
                end
                OP_IDX_CLR:
                    idx_reg <= '0;
                OP_INIT_J:
                begin
                    stored_reg[idx_reg] <= f_home(setup_reg[idx_reg]);
                    idx_reg             <= idx_reg + 3'd1;
                end
                default:
                    idx_reg <= idx_reg;
            endcase
        end
    end

    assign res_valid = rv_reg;
    assign kind      = kind_reg;
    assign channel   = chan_reg;
    assign joint_out = jo_reg;
    assign angle_out = ao_reg;
    assign busy_res  = busy_reg;
    assign last      = last_reg;

endmodule

/* rtl/core/multi_joint_servo_motion_sequencer_top.sv */
// An item is taken in idle and decoded in the next cycle; its first result enters the output
// register from the decode state, or from the init or step state for init and single-joint steps.
// Later results follow one a cycle while the receiver keeps up, except move-all updates: each
// move-all step loads and runs one restoring division per joint before that joint's update.
// One item at a time; reset (rst_n, async, active low) restores setup, home angles, idle.
module multi_joint_servo_motion_sequencer_top
    import mjss_pkg::*;
#(
    parameter int JOINTS      = DEF_JOINTS,
    parameter int BASE_PERIOD = DEF_BASE,
    parameter int ALL_SPEED   = DEF_ALLSPD
)
(
    input  logic          clk,
    input  logic          rst_n,
    // configuration write port
    input  logic          cfg_we,
    input  logic [2:0]    cfg_idx,
    input  logic [31:0]   cfg_data,
    // command item channel
    input  logic          item_valid,
    output logic          item_ready,
    input  logic [2:0]    cmd,
    input  logic [JW-1:0] joint,
    input  logic          all_joints,
    input  logic [AW-1:0] target,
    input  logic [AW-1:0] angle_0,
    input  logic [AW-1:0] angle_1,
    input  logic [AW-1:0] angle_2,
    input  logic [AW-1:0] angle_3,
    input  logic [AW-1:0] angle_4,
    input  logic [AW-1:0] angle_5,
    // result item channel
    output logic          res_valid,
    input  logic          res_ready,
    output logic [2:0]    kind,
    output logic [3:0]    channel,
    output logic [JW-1:0] joint_out,
    output logic [AW-1:0] angle_out,
    output logic          busy_res,
    output logic          last
);

    // Controller and datapath talk only through these two bundles.
    ctl_t          ctl;
    sts_t          sts;
    logic [AW-1:0] angle_in [NREG];

    // Gather the move-all targets into one array for the datapath.
    assign angle_in[0] = angle_0;
    assign angle_in[1] = angle_1;
    assign angle_in[2] = angle_2;
    assign angle_in[3] = angle_3;
    assign angle_in[4] = angle_4;
    assign angle_in[5] = angle_5;

    // Sequencer: takes an item in idle, then walks through its result items,
    // holding whenever the output register is still full.
    mjss_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .sts        (sts),
        .ctl        (ctl)
    );

    // Datapath: setup registers, joint angles, tick counter, divider and
    // the output register that parts the result side from the sequencer.
    mjss_dp #(
        .JOINTS      (JOINTS),
        .BASE_PERIOD (BASE_PERIOD),
        .ALL_SPEED   (ALL_SPEED)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .joint      (joint),
        .all_joints (all_joints),
        .target     (target),
        .angle_in   (angle_in),
        .ctl        (ctl),
        .sts        (sts),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .kind       (kind),
        .channel    (channel),
        .joint_out  (joint_out),
        .angle_out  (angle_out),
        .busy_res   (busy_res),
        .last       (last)
    );

endmodule

/* rtl/core/mjss_checker.sv */
module mjss_checker
    import mjss_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [2:0] kind,
    input logic [3:0] channel,
    input logic [7:0] angle_out,
    input logic       busy_res,
    input logic       last
);

    // Hold a stalled result item.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(angle_out))
        else $error("stalled result changed");

    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind == K_REJECT |-> busy_res && last && angle_out == 8'd0)
        else $error("reject result malformed");

    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind == K_DONE |-> !busy_res && last && channel == 4'd0)
        else $error("done result malformed");

    a_report: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (kind == K_REPORT || kind == K_REJECT) |-> last)
        else $error("single result item not marked last");

endmodule

bind multi_joint_servo_motion_sequencer_top mjss_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .kind      (kind),
    .channel   (channel),
    .angle_out (angle_out),
    .busy_res  (busy_res),
    .last      (last)
);

/* verif/tb_multi_joint_servo_motion_sequencer_top.sv */
module tb_multi_joint_servo_motion_sequencer_top;
    import mjss_pkg::*;

    // One command item as the block sees it on its input channel.
    typedef struct packed {
        logic [2:0]      cmd;
        logic [2:0]      jnt;
        logic            all;
        logic [7:0]      tgt;
        logic [5:0][7:0] ang;
    } servo_cmd_t;

    // One servo result item.
    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] chan;
        logic [2:0] jnt;
        logic [7:0] ang;
        logic       busy;
        logic       last;
    } servo_res_t;

    // Directed row: a command, plus a typed-in single result where it is obvious.
    typedef struct packed {
        servo_cmd_t item;
        logic       typed;
        logic [2:0] tk;
        logic [7:0] ta;
    } drive_row_t;

    localparam int N_JOINT      = DEF_JOINTS;
    localparam int ALL_PERIOD   = DEF_BASE / DEF_ALLSPD;
    localparam int ITEMS_PHASE  = 35;
    localparam int SETTLE_CYC   = 150;
    localparam int HOLD_CYC     = 300;
    localparam logic [2:0] CMD_IGN6 = 3'd6;
    localparam logic [2:0] CMD_IGN7 = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [31:0] cfg_data;
    logic        item_valid;
    logic        item_ready;
    logic [2:0]  cmd;
    logic [2:0]  joint;
    logic        all_joints;
    logic [7:0]  target;
    logic [7:0]  angle_0, angle_1, angle_2, angle_3, angle_4, angle_5;
    logic        res_valid;
    logic        res_ready;
    logic [2:0]  kind;
    logic [3:0]  channel;
    logic [2:0]  joint_out;
    logic [7:0]  angle_out;
    logic        busy_res;
    logic        last;

    multi_joint_servo_motion_sequencer_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .cmd        (cmd),
        .joint      (joint),
        .all_joints (all_joints),
        .target     (target),
        .angle_0    (angle_0),
        .angle_1    (angle_1),
        .angle_2    (angle_2),
        .angle_3    (angle_3),
        .angle_4    (angle_4),
        .angle_5    (angle_5),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .kind       (kind),
        .channel    (channel),
        .joint_out  (joint_out),
        .angle_out  (angle_out),
        .busy_res   (busy_res),
        .last       (last)
    );

    // Shadow copy of the sequencer: setup registers plus motion state.
    logic [31:0] setup_sh [N_JOINT];
    logic [7:0]  stored_sh [N_JOINT];
    logic [7:0]  goal_sh [N_JOINT];
    logic [7:0]  moving_sh;
    mode_t       mode_sh;
    logic [2:0]  active_sh;
    logic [7:0]  step_idx_sh;
    logic [7:0]  step_tot_sh;
    logic [4:0]  tick_sh;

    servo_res_t  motion_results [$];   // results of the current item
    servo_res_t  pending_results [$];  // results still owed by the block
    int          mismatches;
    bit          quiet;                // last part: no idling at all
    bit          hold_req;             // ask the receiver for a long hold-off

    // ---------------- predictor ----------------

    function automatic logic [7:0] clamp_sh(input int j, input logic [7:0] a);
        if (a < setup_sh[j][7:0])
            return setup_sh[j][7:0];
        if (a > setup_sh[j][15:8])
            return setup_sh[j][15:8];
        return a;
    endfunction

    function automatic void emit(input logic [2:0] k, input logic [3:0] ch,
                                 input logic [2:0] j, input logic [7:0] a,
                                 input logic b);
        servo_res_t r;
        r.kind = k;
        r.chan = ch;
        r.jnt  = j;
        r.ang  = a;
        r.busy = b;
        r.last = 1'b0;
        motion_results.push_back(r);
    endfunction

    function automatic int next_moving(input int from);
        for (int i = from; i < N_JOINT; i++)
            if (goal_sh[i] != stored_sh[i])
                return i;
        return -1;
    endfunction

    function automatic void start_joint(input int j);
        active_sh = 3'(j);
        moving_sh = stored_sh[j];
        tick_sh   = '0;
    endfunction

    function automatic int step_period();
        int s;
        if (mode_sh == MODE_ALL)
            return (ALL_PERIOD == 0) ? 1 : ALL_PERIOD;
        s = setup_sh[active_sh][27:24];
        if (s < 1)
            s = 1;
        if (s > SPEED_MAX)
            s = SPEED_MAX;
        return (DEF_BASE / s == 0) ? 1 : DEF_BASE / s;
    endfunction

    function automatic void joint_step();
        int a;
        int nx;
        a = active_sh;
        if (goal_sh[a] > moving_sh)
            moving_sh++;
        else if (goal_sh[a] < moving_sh)
            moving_sh--;
        emit(K_UPDATE, setup_sh[a][31:28], 3'(a), moving_sh, 1'b1);
        if (moving_sh != goal_sh[a])
            return;
        stored_sh[a] = goal_sh[a];
        if (mode_sh == MODE_HOMEALL) begin
            nx = next_moving(a + 1);
            if (nx >= 0) begin
                start_joint(nx);
                return;
            end
            mode_sh = MODE_IDLE;
            emit(K_DONE, 4'd0, 3'd0, 8'd0, 1'b0);
        end
        else begin
            mode_sh = MODE_IDLE;
            emit(K_DONE, 4'd0, 3'(a), goal_sh[a], 1'b0);
        end
    endfunction

    function automatic void sweep_step();
        int m;
        int c;
        int t;
        int v;
        m = (step_tot_sh != 0) ? int'(step_tot_sh) : 1;
        step_idx_sh++;
        for (int i = 0; i < N_JOINT; i++) begin
            c = stored_sh[i];
            t = goal_sh[i];
            v = int'(step_idx_sh) * (t - c) / m + c;
            emit(K_UPDATE, setup_sh[i][31:28], 3'(i), 8'(v), 1'b1);
        end
        if (step_idx_sh >= step_tot_sh) begin
            for (int i = 0; i < N_JOINT; i++)
                stored_sh[i] = goal_sh[i];
            mode_sh = MODE_IDLE;
            emit(K_DONE, 4'd0, 3'd0, 8'd0, 1'b0);
        end
    endfunction

    function automatic void start_single(input logic [2:0] j, input logic [7:0] tgt);
        logic [7:0] g;
        if (j >= N_JOINT) begin
            emit(K_ACCEPT, 4'd0, j, 8'd0, 1'b0);
            emit(K_DONE, 4'd0, j, 8'd0, 1'b0);
            return;
        end
        g = clamp_sh(j, tgt);
        goal_sh[j] = g;
        if (g == stored_sh[j]) begin
            emit(K_ACCEPT, 4'd0, j, g, 1'b0);
            emit(K_DONE, 4'd0, j, g, 1'b0);
            return;
        end
        mode_sh = MODE_ONE;
        start_joint(j);
        emit(K_ACCEPT, 4'd0, j, g, 1'b1);
    endfunction

    // Advance the shadow by one item; leave its results in motion_results.
    function automatic void predict_motion(input servo_cmd_t it);
        int mx;
        int d;
        int nx;
        logic [7:0] g;
        motion_results.delete();
        if (it.cmd == CMD_TICK) begin
            if (mode_sh == MODE_IDLE)
                return;
            tick_sh = tick_sh + 5'd1;
            if (tick_sh < step_period())
                return;
            tick_sh = '0;
            if (mode_sh == MODE_ALL)
                sweep_step();
            else
                joint_step();
        end
        else if (it.cmd > CMD_QUERY) begin
            return;
        end
        else if (mode_sh != MODE_IDLE) begin
            emit(K_REJECT, 4'd0, it.jnt, 8'd0, 1'b1);
        end
        else if (it.cmd == CMD_MOVE1) begin
            start_single(it.jnt, it.tgt);
        end
        else if (it.cmd == CMD_MOVEA) begin
            mx = 0;
            for (int i = 0; i < N_JOINT; i++) begin
                g = clamp_sh(i, it.ang[i]);
                d = (g > stored_sh[i]) ? g - stored_sh[i] : stored_sh[i] - g;
                goal_sh[i] = g;
                if (d > mx)
                    mx = d;
            end
            if (mx == 0) begin
                emit(K_ACCEPT, 4'd0, 3'd0, 8'd0, 1'b0);
                emit(K_DONE, 4'd0, 3'd0, 8'd0, 1'b0);
            end
            else begin
                mode_sh     = MODE_ALL;
                step_idx_sh = '0;
                step_tot_sh = 8'(mx);
                tick_sh     = '0;
                emit(K_ACCEPT, 4'd0, 3'd0, 8'd0, 1'b1);
            end
        end
        else if (it.cmd == CMD_HOME) begin
            if (it.all) begin
                for (int i = 0; i < N_JOINT; i++)
                    goal_sh[i] = clamp_sh(i, setup_sh[i][23:16]);
                nx = next_moving(0);
                if (nx < 0) begin
                    emit(K_ACCEPT, 4'd0, 3'd0, 8'd0, 1'b0);
                    emit(K_DONE, 4'd0, 3'd0, 8'd0, 1'b0);
                end
                else begin
                    mode_sh = MODE_HOMEALL;
                    start_joint(nx);
                    emit(K_ACCEPT, 4'd0, 3'd0, 8'd0, 1'b1);
                end
            end
            else begin
                start_single(it.jnt, (it.jnt < N_JOINT) ? setup_sh[it.jnt][23:16] : 8'd0);
            end
        end
        else if (it.cmd == CMD_INIT) begin
            for (int i = 0; i < N_JOINT; i++) begin
                stored_sh[i] = setup_sh[i][23:16];
                emit(K_UPDATE, setup_sh[i][31:28], 3'(i), stored_sh[i], 1'b0);
            end
            emit(K_DONE, 4'd0, 3'd0, 8'd0, 1'b0);
        end
        else begin
            emit(K_REPORT, 4'd0, it.jnt,
                 (it.jnt < N_JOINT) ? stored_sh[it.jnt] : 8'd0, 1'b0);
        end
        if (motion_results.size() > 0)
            motion_results[motion_results.size() - 1].last = 1'b1;
    endfunction

    // ---------------- clock, reset, limit ----------------

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // ---------------- result side ----------------

    // Drive ready: random idle bursts, one long hold-off on request, none when quiet.
    initial begin
        int gap;
        int hold;
        gap  = 0;
        hold = 0;
        res_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && hold == 0) begin
                hold     = HOLD_CYC;
                hold_req = 1'b0;
            end
            if (hold > 0) begin
                hold--;
                res_ready <= 1'b0;
            end
            else if (gap > 0) begin
                gap--;
                res_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 9) - 1;
                res_ready <= 1'b0;
            end
            else begin
                res_ready <= 1'b1;
            end
        end
    end

    // Check at the falling edge: a result seen here is taken at the next rising edge.
    always @(negedge clk) begin
        servo_res_t want;
        servo_res_t got;
        if (rst_n && res_valid && res_ready) begin
            got = '{kind, channel, joint_out, angle_out, busy_res, last};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result kind=%0d joint=%0d angle=%0d",
                             kind, joint_out, angle_out);
            end
            else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: exp kind=%0d ch=%0d j=%0d a=%0d",
                                 want.kind, want.chan, want.jnt, want.ang,
                                 " b=%0d l=%0d,", want.busy, want.last,
                                 " got kind=%0d ch=%0d j=%0d a=%0d",
                                 got.kind, got.chan, got.jnt, got.ang,
                                 " b=%0d l=%0d", got.busy, got.last);
                end
            end
        end
    end

    // ---------------- command side ----------------

    // Offer one item; hold it until taken, then record what it should produce.
    // Entered and left at a rising edge.
    task automatic offer_item(input servo_cmd_t it, input logic typed,
                              input logic [2:0] tk, input logic [7:0] ta);
        servo_res_t r;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        cmd        <= it.cmd;
        joint      <= it.jnt;
        all_joints <= it.all;
        target     <= it.tgt;
        angle_0    <= it.ang[0];
        angle_1    <= it.ang[1];
        angle_2    <= it.ang[2];
        angle_3    <= it.ang[3];
        angle_4    <= it.ang[4];
        angle_5    <= it.ang[5];
        item_valid <= 1'b1;
        do
            @(negedge clk);
        while (!item_ready);
        predict_motion(it);
        if (typed) begin
            // single obvious result, typed in by hand
            r = '{tk, 4'd0, it.jnt, ta, (tk == K_REJECT), 1'b1};
            pending_results.push_back(r);
        end
        else begin
            foreach (motion_results[i])
                pending_results.push_back(motion_results[i]);
        end
        @(posedge clk);
    endtask

    // Drop valid, wait for every owed result, then let the block finish any silent work.
    task automatic drain_results();
        item_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_setup(input int idx, input logic [31:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= 3'(idx);
        cfg_data <= val;
        setup_sh[idx] = val;
        @(posedge clk);
    endtask

    function automatic servo_cmd_t make_cmd(input logic [2:0] c, input logic [2:0] j,
                                            input logic a, input logic [7:0] t,
                                            input logic [47:0] angs);
        servo_cmd_t it;
        it.cmd = c;
        it.jnt = j;
        it.all = a;
        it.tgt = t;
        it.ang = angs;
        return it;
    endfunction

    // Narrow limits keep motions short; home may sit just outside them.
    function automatic logic [31:0] narrow_setup();
        int lo;
        int hi;
        int hm;
        lo = $urandom_range(0, 249);
        hi = lo + $urandom_range(0, 6);
        if ($urandom_range(0, 5) == 0) begin
            hm = lo;
            lo = hi;
            hi = hm;
        end
        hm = $urandom_range((lo < hi ? lo : hi) > 4 ? (lo < hi ? lo : hi) - 4 : 0,
                            (lo > hi ? lo : hi) + 4 > 255 ? 255 : (lo > hi ? lo : hi) + 4);
        return {4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                8'(hm), 8'(hi), 8'(lo)};
    endfunction

    function automatic servo_cmd_t random_cmd();
        servo_cmd_t it;
        int w;
        it = make_cmd(CMD_TICK, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)),
                      {$urandom(), 16'($urandom())});
        w = $urandom_range(0, 99);
        if (mode_sh != MODE_IDLE) begin
            // mostly advance the motion; sometimes poke it with a command
            if (w >= 88)
                it.cmd = 3'($urandom_range(1, 7));
        end
        else if (w < 28) it.cmd = CMD_MOVE1;
        else if (w < 48) it.cmd = CMD_MOVEA;
        else if (w < 64) it.cmd = CMD_HOME;
        else if (w < 70) it.cmd = CMD_INIT;
        else if (w < 84) it.cmd = CMD_QUERY;
        else if (w < 90) it.cmd = ($urandom_range(0, 1) != 0) ? CMD_IGN6 : CMD_IGN7;
        // else an idle tick
        if (it.cmd != CMD_TICK && it.jnt >= N_JOINT && $urandom_range(0, 2) != 0)
            it.jnt = 3'($urandom_range(0, N_JOINT - 1));
        return it;
    endfunction

    initial begin
        drive_row_t rows [$];
        servo_cmd_t it;
        int done_cnt;
        bit counts;
        logic [31:0] val;

        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_idx    = '0;
        cfg_data   = '0;
        item_valid = 1'b0;
        cmd        = CMD_TICK;
        joint      = '0;
        all_joints = 1'b0;
        target     = '0;
        angle_0 = '0; angle_1 = '0; angle_2 = '0;
        angle_3 = '0; angle_4 = '0; angle_5 = '0;
        mismatches = 0;
        quiet      = 1'b0;
        hold_req   = 1'b0;

        for (int i = 0; i < N_JOINT; i++) begin
            setup_sh[i]  = SETUP_RST | (32'(i) << 28);
            stored_sh[i] = HOME_RST;
            goal_sh[i]   = '0;
        end
        moving_sh = '0; mode_sh = MODE_IDLE; active_sh = '0;
        step_idx_sh = '0; step_tot_sh = '0; tick_sh = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, on the reset setup.
        rows.push_back('{make_cmd(CMD_QUERY, 3'd0, 1'b0, 8'd0, '0), 1'b1, K_REPORT, 8'd90});
        rows.push_back('{make_cmd(CMD_QUERY, 3'd7, 1'b0, 8'd0, '0), 1'b1, K_REPORT, 8'd0});
        rows.push_back('{make_cmd(CMD_IGN6, 3'd0, 1'b0, 8'd0, '0), 1'b0, K_UPDATE, 8'd0});
        rows.push_back('{make_cmd(CMD_IGN7, 3'd5, 1'b1, 8'd255, '1), 1'b0, K_UPDATE, 8'd0});
        rows.push_back('{make_cmd(CMD_MOVE1, 3'd6, 1'b0, 8'd0, '0), 1'b0, K_UPDATE, 8'd0});
        rows.push_back('{make_cmd(CMD_HOME, 3'd7, 1'b0, 8'd0, '0), 1'b0, K_UPDATE, 8'd0});
        rows.push_back('{make_cmd(CMD_INIT, 3'd0, 1'b0, 8'd0, '0), 1'b0, K_UPDATE, 8'd0});
        rows.push_back('{make_cmd(CMD_MOVE1, 3'd1, 1'b0, 8'd90, '0), 1'b0, K_UPDATE, 8'd0});
        rows.push_back('{make_cmd(CMD_MOVE1, 3'd2, 1'b0, 8'd91, '0), 1'b0, K_UPDATE, 8'd0});
        rows.push_back('{make_cmd(CMD_QUERY, 3'd2, 1'b0, 8'd0, '0), 1'b1, K_REJECT, 8'd0});
        repeat (4)
            rows.push_back('{make_cmd(CMD_TICK, 3'd0, 1'b0, 8'd0, '0), 1'b0, K_UPDATE, 8'd0});
        rows.push_back('{make_cmd(CMD_TICK, 3'd0, 1'b0, 8'd0, '0), 1'b0, K_UPDATE, 8'd0});
        rows.push_back('{make_cmd(CMD_MOVEA, 3'd0, 1'b0, 8'd0,
                                  {8'd90, 8'd90, 8'd92, 8'd90, 8'd89, 8'd91}),
                         1'b0, K_UPDATE, 8'd0});
        rows.push_back('{make_cmd(CMD_HOME, 3'd0, 1'b1, 8'd0, '0), 1'b1, K_REJECT, 8'd0});
        repeat (8)
            rows.push_back('{make_cmd(CMD_TICK, 3'd0, 1'b0, 8'd0, '0), 1'b0, K_UPDATE, 8'd0});
        foreach (rows[i])
            offer_item(rows[i].item, rows[i].typed, rows[i].tk, rows[i].ta);

        // Random phases: narrow setup, all zeros, narrow with long hold-off,
        // all ones, narrow with no idling.
        for (int ph = 0; ph < 5; ph++) begin
            drain_results();
            for (int r = 0; r < NREG; r++) begin
                if (ph == 1)
                    val = '0;
                else if (ph == 3)
                    val = '1;
                else
                    val = narrow_setup();
                write_setup(r, val);
            end
            cfg_we <= 1'b0;
            quiet    = (ph == 4);
            hold_req = (ph == 2);
            // start each phase from the new home angles
            offer_item(make_cmd(CMD_INIT, 3'd0, 1'b0, 8'd0, '0), 1'b0, K_UPDATE, 8'd0);
            done_cnt = 1;
            while (done_cnt < ITEMS_PHASE) begin
                it = random_cmd();
                counts = !(it.cmd > CMD_QUERY || (it.cmd == CMD_TICK && mode_sh == MODE_IDLE));
                offer_item(it, 1'b0, K_UPDATE, 8'd0);
                if (counts)
                    done_cnt++;
            end
        end

        drain_results();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* multi_joint_servo_motion_sequencer_top.f */
rtl/core/mjss_pkg.sv
rtl/core/mjss_ctrl.sv
rtl/core/mjss_dp.sv
rtl/core/multi_joint_servo_motion_sequencer_top.sv
rtl/core/mjss_checker.sv
verif/tb_multi_joint_servo_motion_sequencer_top.sv
